/* sv/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_CLK_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/fct_pkg.sv */
// shared types and constants for the frustum cull block
package fct_pkg;

   localparam int PLANE_COUNT_DEF = 6;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int COEF_W          = 32;
   localparam int COORD_W         = 32;
   localparam int RADIUS_W        = 31;
   localparam int PROD_W          = 64;
   // three full products plus scaled offset and radius, for any fraction width up to 24
   localparam int ACC_W           = 66;
   localparam int COEF_NUM        = 4;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_BOX    = 2'd1,
      OP_SPHERE = 2'd2,
      OP_POLY   = 2'd3
   } opcode_type;

   // coefficient select, also the step of the multiply-accumulate sequence
   typedef enum logic [1:0] {
      AXIS_X   = 2'd0,
      AXIS_Y   = 2'd1,
      AXIS_Z   = 2'd2,
      AXIS_OFS = 2'd3
   } coef_sel_type;

   typedef struct packed {
      opcode_type                 op;
      logic signed [COORD_W-1:0]  pos_x;
      logic signed [COORD_W-1:0]  pos_y;
      logic signed [COORD_W-1:0]  pos_z;
      logic signed [COORD_W-1:0]  far_x;
      logic signed [COORD_W-1:0]  far_y;
      logic signed [COORD_W-1:0]  far_z;
      logic [RADIUS_W-1:0]        radius;
      logic                       last_point;
   } item_type;

   typedef struct packed {
      logic         run;
      coef_sel_type step;
      logic         commit;
   } cell_ctrl_type;

   typedef struct packed {
      logic                      en;
      coef_sel_type              sel;
      logic signed [COEF_W-1:0]  data;
   } coef_wr_type;

endpackage

/* sv/fct_cell.sv */
// one clip plane cell: coefficients, multiply-accumulate and polygon flag
module fct_cell #(
   parameter int FRAC_BITS = fct_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fct_pkg::coef_wr_type   wr,
   input  fct_pkg::item_type      item,
   input  fct_pkg::cell_ctrl_type ctrl,
   input  logic                   keep_prev,
   output logic                   keep_next
);

   localparam int ACC_W   = fct_pkg::ACC_W;
   localparam int COEF_W  = fct_pkg::COEF_W;
   localparam int COORD_W = fct_pkg::COORD_W;
   localparam int PROD_W  = fct_pkg::PROD_W;

   logic signed [COEF_W-1:0]  coef_ff [fct_pkg::COEF_NUM];
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [ACC_W-1:0]          base_ff, base_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic                      seen_ff, seen_in;

   logic signed [COEF_W-1:0]  cur_coef;
   logic signed [COORD_W-1:0] pos_c, far_c, hi_c, lo_c, coord;
   logic [ACC_W-1:0]          rad_term;
   logic                      acc_neg, acc_pos, keep;

   always_comb begin
      cur_coef = coef_ff[ctrl.step];
      case (ctrl.step)
         fct_pkg::AXIS_X: begin
            pos_c = item.pos_x;
            far_c = item.far_x;
         end
         fct_pkg::AXIS_Y: begin
            pos_c = item.pos_y;
            far_c = item.far_y;
         end
         fct_pkg::AXIS_Z: begin
            pos_c = item.pos_z;
            far_c = item.far_z;
         end
         default: begin
            pos_c = item.pos_x;
            far_c = item.far_x;
         end
      endcase
      hi_c = (far_c > pos_c) ? far_c : pos_c;
      lo_c = (far_c > pos_c) ? pos_c : far_c;
      // box: the corner that maximises the distance decides whether all corners are behind
      if (item.op == fct_pkg::OP_BOX) begin
         coord = cur_coef[COEF_W-1] ? lo_c : hi_c;
      end else begin
         coord = pos_c;
      end
      prod_in = cur_coef * coord;

      rad_term = (item.op == fct_pkg::OP_SPHERE) ? (ACC_W'(item.radius) << FRAC_BITS) : '0;
      base_in  = (ACC_W'(coef_ff[fct_pkg::AXIS_OFS]) << FRAC_BITS) + rad_term;

      case (ctrl.step)
         fct_pkg::AXIS_X: acc_in = acc_ff;
         fct_pkg::AXIS_Y: acc_in = base_ff + ACC_W'(prod_ff);
         default:         acc_in = acc_ff + ACC_W'(prod_ff);
      endcase
   end

   assign acc_neg = acc_ff[ACC_W-1];
   assign acc_pos = !acc_neg && (|acc_ff);

   always_comb begin
      case (item.op)
         fct_pkg::OP_BOX:    keep = !acc_neg;
         fct_pkg::OP_SPHERE: keep = acc_pos;
         fct_pkg::OP_POLY:   keep = seen_ff | acc_pos;
         default:            keep = 1'b1;
      endcase
      seen_in = seen_ff;
      if (ctrl.commit && item.op == fct_pkg::OP_POLY) begin
         seen_in = item.last_point ? 1'b0 : (seen_ff | acc_pos);
      end
   end

   assign keep_next = keep_prev & keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fct_pkg::COEF_NUM; i++) begin
            coef_ff[i] <= '0;
         end
         seen_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            coef_ff[wr.sel] <= wr.data;
         end
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.run) begin
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
         if (ctrl.step == fct_pkg::AXIS_X) begin
            base_ff <= base_in;
         end
      end
   end

endmodule

/* sv/frustum_cull_test_top.sv */
// frustum cull top level: sequencer, row of plane cells, result register
// a coefficient load gives no word back
// a test word runs the four-step multiply-accumulate of each plane cell, then waits for the output
// word to be free if it gives one; a new word is taken only once the block is idle again
// synchronous reset clears all plane coefficients and polygon flags at once and empties the output
module frustum_cull_test_top #(
   parameter int PLANE_COUNT = fct_pkg::PLANE_COUNT_DEF,
   parameter int FRAC_BITS   = fct_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_opcode,
   input  logic [2:0]                           req_plane_index,
   input  logic [1:0]                           req_coef_index,
   input  logic signed [fct_pkg::COEF_W-1:0]    req_coef_value,
   input  logic signed [fct_pkg::COORD_W-1:0]   req_pos_x,
   input  logic signed [fct_pkg::COORD_W-1:0]   req_pos_y,
   input  logic signed [fct_pkg::COORD_W-1:0]   req_pos_z,
   input  logic signed [fct_pkg::COORD_W-1:0]   req_far_x,
   input  logic signed [fct_pkg::COORD_W-1:0]   req_far_y,
   input  logic signed [fct_pkg::COORD_W-1:0]   req_far_z,
   input  logic [fct_pkg::RADIUS_W-1:0]         req_radius,
   input  logic                                 req_last_point,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_visible
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   fct_pkg::coef_sel_type  step_ff, step_in;
   fct_pkg::item_type      item_ff, item_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_visible_ff, rsp_visible_in;
   logic                   commit;
   logic                   need_rsp;
   logic                   load_acc;
   fct_pkg::opcode_type    req_op;
   fct_pkg::cell_ctrl_type ctrl;
   logic [PLANE_COUNT:0]   keep_chain;

   assign req_op    = fct_pkg::opcode_type'(req_opcode);
   assign req_ready = (state_ff == S_IDLE);
   assign load_acc  = req_valid && req_ready && (req_op == fct_pkg::OP_LOAD);
   assign need_rsp  = (item_ff.op != fct_pkg::OP_POLY) || item_ff.last_point;

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      item_in        = item_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_visible_in = rsp_visible_ff;
      commit         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_op != fct_pkg::OP_LOAD) begin
               item_in.op         = req_op;
               item_in.pos_x      = req_pos_x;
               item_in.pos_y      = req_pos_y;
               item_in.pos_z      = req_pos_z;
               item_in.far_x      = req_far_x;
               item_in.far_y      = req_far_y;
               item_in.far_z      = req_far_z;
               item_in.radius     = req_radius;
               item_in.last_point = req_last_point;
               step_in            = fct_pkg::AXIS_X;
               state_in           = S_RUN;
            end
         end
         S_RUN: begin
            if (step_ff == fct_pkg::AXIS_OFS) begin
               state_in = S_DONE;
            end else begin
               step_in = fct_pkg::coef_sel_type'(2'(step_ff + 2'd1));
            end
         end
         S_DONE: begin
            // when a word is due, hold the verdict until the output word is free
            if (!need_rsp) begin
               commit   = 1'b1;
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               commit         = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_visible_in = keep_chain[PLANE_COUNT];
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= fct_pkg::AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff        <= item_in;
      rsp_visible_ff <= rsp_visible_in;
   end

   assign ctrl.run    = (state_ff == S_RUN);
   assign ctrl.step   = step_ff;
   assign ctrl.commit = commit;

   assign keep_chain[0] = 1'b1;

   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
      fct_pkg::coef_wr_type wr;
      assign wr.en   = load_acc && (req_plane_index == 3'(p));
      assign wr.sel  = fct_pkg::coef_sel_type'(req_coef_index);
      assign wr.data = req_coef_value;

      fct_cell #(
         .FRAC_BITS (FRAC_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr        (wr),
         .item      (item_ff),
         .ctrl      (ctrl),
         .keep_prev (keep_chain[p]),
         .keep_next (keep_chain[p+1])
      );
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

endmodule

/* sv/fct_checker.sv */
// port-level checks for the frustum cull top level, bound to it below
`include "assert_macros.svh"

module fct_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_opcode,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_visible
);

   // a stalled result word holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_visible), "result word changed while stalled")

   // a test occupies the block, a load does not
   `ASSERT_CLK(a_test_busy, clock, reset, req_valid && req_ready && req_opcode != fct_pkg::OP_LOAD |=> !req_ready, "word taken while a test is running")
   `ASSERT_CLK(a_load_free, clock, reset, req_valid && req_ready && req_opcode == fct_pkg::OP_LOAD |=> req_ready, "block busy after a coefficient load")

   // after reset the output is empty and the input open
   `ASSERT_CLK_NR(a_reset_state, clock, reset |=> !rsp_valid && req_ready, "wrong state after reset")

   // a new result only comes out of a running test
   `ASSERT_CLK(a_rsp_from_test, clock, reset, $rose(rsp_valid) |-> !$past(req_ready), "result without a running test")

endmodule

bind frustum_cull_test_top fct_checker u_fct_checker (.*);
